>>> src/lps_pkg.sv
// ----------------------------------------------------------------------------
// Layer priority compositor package
// Shared widths, codes, configuration and control types for the compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

  localparam int unsigned PIX_W         = 16;
  localparam int unsigned NUM_BG        = 4;
  localparam int unsigned NUM_SLOT      = 4;
  localparam int unsigned RANK_PER_SLOT = NUM_BG + 1;
  localparam int unsigned NUM_RANK      = NUM_SLOT * RANK_PER_SLOT;
  localparam int unsigned NUM_CHAN      = 3;
  localparam int unsigned CHAN_W        = 5;
  localparam int unsigned COEFF_W       = 5;
  localparam int unsigned PROD_W        = 10;
  localparam int unsigned NUM_STAGE     = 4;
  localparam int unsigned REG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [PIX_W-1:0]   TRANSPARENT_CODE = 16'h8000;
  localparam logic [CHAN_W-1:0]  CHAN_MAX         = 5'd31;
  localparam logic [COEFF_W-1:0] COEFF_MAX        = 5'd16;

  // Layer codes as reported on the output.
  localparam logic [2:0] LAYER_SPRITE   = 3'd4;
  localparam logic [2:0] LAYER_BACKDROP = 3'd5;

  // Effect modes.
  localparam logic [1:0] EFF_NONE   = 2'd0;
  localparam logic [1:0] EFF_ALPHA  = 2'd1;
  localparam logic [1:0] EFF_BRIGHT = 2'd2;
  localparam logic [1:0] EFF_DARK   = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_EFFECT_MODE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_A        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_B        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_Y        = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BG_PRIORITIES  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LAYER_ENABLES  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_SELECTS = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_BD_COLOR       = 3'd7;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [2:0]       layer_t;

  typedef struct packed {
    logic [1:0]         effect_mode;
    logic [COEFF_W-1:0] coeff_a;
    logic [COEFF_W-1:0] coeff_b;
    logic [COEFF_W-1:0] coeff_y;
    logic [7:0]         bg_priorities;
    logic [4:0]         layer_enables;
    logic [11:0]        target_selects;
    pixel_t             bd_color;
  } cfg_t;

  // Load enables for the two register stages inside one submodule.
  typedef struct packed {
    logic first;
    logic second;
  } adv_t;

  function automatic logic [COEFF_W-1:0] cap16(input logic [COEFF_W-1:0] v);
    return (v > COEFF_MAX) ? COEFF_MAX : v;
  endfunction

endpackage

`default_nettype wire

>>> src/lps_layer_sel.sv
// ----------------------------------------------------------------------------
// Layer selection
// Qualifies every layer pixel, then picks the top and second layer.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_layer_sel (
  input  wire                              clk_i,
  input  wire lps_pkg::cfg_t               cfg_i,
  input  wire lps_pkg::adv_t               adv_i,
  input  wire lps_pkg::pixel_t [3:0]       bg_pixel_i,
  input  wire lps_pkg::pixel_t [3:0]       spr_pixel_i,
  input  wire [5:0]                        visible_mask_i,
  output lps_pkg::pixel_t                  top_pix_o,
  output lps_pkg::pixel_t                  sec_pix_o,
  output lps_pkg::layer_t                  top_lay_o,
  output lps_pkg::layer_t                  sec_lay_o,
  output logic                             eff_vis_o
);
  import lps_pkg::*;

  // Stage 1: qualified pixels.
  pixel_t [NUM_BG-1:0]   bg_q;
  pixel_t [NUM_SLOT-1:0] spr_q;
  logic   [NUM_BG-1:0]   bg_ok_q, bg_ok_d;
  logic   [NUM_SLOT-1:0] spr_ok_q, spr_ok_d;
  logic                  eff_vis_q;

  // Stage 2: selected layers.
  pixel_t top_pix_q, top_pix_d;
  pixel_t sec_pix_q, sec_pix_d;
  layer_t top_lay_q, top_lay_d;
  layer_t sec_lay_q, sec_lay_d;
  logic   eff_vis2_q;

  logic   [NUM_RANK-1:0] req, rest, top_oh, sec_oh;
  pixel_t [NUM_RANK-1:0] cand_pix;
  layer_t [NUM_RANK-1:0] cand_lay;

  always_comb begin
    for (int k = 0; k < NUM_BG; k++) begin
      bg_ok_d[k] = cfg_i.layer_enables[k] & visible_mask_i[k] &
                   (bg_pixel_i[k] != TRANSPARENT_CODE);
    end
    for (int s = 0; s < NUM_SLOT; s++) begin
      spr_ok_d[s] = cfg_i.layer_enables[NUM_BG] & visible_mask_i[NUM_BG] &
                    (spr_pixel_i[s] != TRANSPARENT_CODE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.first) begin
      bg_q      <= bg_pixel_i;
      spr_q     <= spr_pixel_i;
      bg_ok_q   <= bg_ok_d;
      spr_ok_q  <= spr_ok_d;
      eff_vis_q <= visible_mask_i[5];
    end
  end

  // Rank 0 is the strongest candidate: slot 0 sprite, then slot 0
  // backgrounds 0 to 3, then slot 1, and so on.
  always_comb begin
    for (int s = 0; s < NUM_SLOT; s++) begin
      for (int w = 0; w < RANK_PER_SLOT; w++) begin
        if (w == 0) begin
          req[s*RANK_PER_SLOT + w]      = spr_ok_q[s];
          cand_pix[s*RANK_PER_SLOT + w] = spr_q[s];
          cand_lay[s*RANK_PER_SLOT + w] = LAYER_SPRITE;
        end else begin
          req[s*RANK_PER_SLOT + w]      = bg_ok_q[w-1] &
              (cfg_i.bg_priorities[2*(w-1) +: 2] == 2'(s));
          cand_pix[s*RANK_PER_SLOT + w] = bg_q[w-1];
          cand_lay[s*RANK_PER_SLOT + w] = 3'(w-1);
        end
      end
    end
  end

  assign rest   = req & (req - 1'b1);
  assign top_oh = req & ~(req - 1'b1);
  assign sec_oh = rest & ~(rest - 1'b1);

  always_comb begin
    top_pix_d = '0;
    sec_pix_d = '0;
    top_lay_d = '0;
    sec_lay_d = '0;
    for (int r = 0; r < NUM_RANK; r++) begin
      top_pix_d = top_pix_d | ({PIX_W{top_oh[r]}} & cand_pix[r]);
      sec_pix_d = sec_pix_d | ({PIX_W{sec_oh[r]}} & cand_pix[r]);
      top_lay_d = top_lay_d | ({3{top_oh[r]}} & cand_lay[r]);
      sec_lay_d = sec_lay_d | ({3{sec_oh[r]}} & cand_lay[r]);
    end
    // The backdrop sits at the bottom of the stack; below it is black.
    if (req == '0) begin
      top_pix_d = cfg_i.bd_color;
      top_lay_d = LAYER_BACKDROP;
      sec_pix_d = '0;
      sec_lay_d = LAYER_BACKDROP;
    end else if (rest == '0) begin
      sec_pix_d = cfg_i.bd_color;
      sec_lay_d = LAYER_BACKDROP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.second) begin
      top_pix_q  <= top_pix_d;
      sec_pix_q  <= sec_pix_d;
      top_lay_q  <= top_lay_d;
      sec_lay_q  <= sec_lay_d;
      eff_vis2_q <= eff_vis_q;
    end
  end

  assign top_pix_o = top_pix_q;
  assign sec_pix_o = sec_pix_q;
  assign top_lay_o = top_lay_q;
  assign sec_lay_o = sec_lay_q;
  assign eff_vis_o = eff_vis2_q;

endmodule

`default_nettype wire

>>> src/lps_blend.sv
// ----------------------------------------------------------------------------
// Color effect
// Decides whether the effect applies, forms the per-channel products, then
// scales and saturates them into the final color.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_blend (
  input  wire                 clk_i,
  input  wire lps_pkg::cfg_t  cfg_i,
  input  wire lps_pkg::adv_t  adv_i,
  input  wire lps_pkg::pixel_t top_pix_i,
  input  wire lps_pkg::pixel_t sec_pix_i,
  input  wire lps_pkg::layer_t top_lay_i,
  input  wire lps_pkg::layer_t sec_lay_i,
  input  wire                 eff_vis_i,
  output lps_pkg::pixel_t     color_o,
  output lps_pkg::layer_t     layer_o
);
  import lps_pkg::*;

  logic [COEFF_W-1:0] coef_a, coef_b, coef_y;
  logic [5:0]         first_sel, second_sel;
  logic               apply_d, apply_q;
  pixel_t             pix3_q;
  layer_t             lay3_q;
  logic [PROD_W-1:0]  prod_d [NUM_CHAN];
  logic [PROD_W-1:0]  prod_q [NUM_CHAN];

  pixel_t             color_d, color_q;
  layer_t             layer_q;
  logic [CHAN_W-1:0]  chan_res [NUM_CHAN];

  assign coef_a     = cap16(cfg_i.coeff_a);
  assign coef_b     = cap16(cfg_i.coeff_b);
  assign coef_y     = cap16(cfg_i.coeff_y);
  assign first_sel  = cfg_i.target_selects[5:0] >> top_lay_i;
  assign second_sel = cfg_i.target_selects[11:6] >> sec_lay_i;

  // Only alpha blending needs the second layer to be a target.
  assign apply_d = (cfg_i.effect_mode != EFF_NONE) & eff_vis_i & first_sel[0] &
                   (second_sel[0] | (cfg_i.effect_mode != EFF_ALPHA));

  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      unique case (cfg_i.effect_mode)
        EFF_ALPHA: begin
          prod_d[ch] = PROD_W'(top_pix_i[ch*CHAN_W +: CHAN_W]) * PROD_W'(coef_a) +
                       PROD_W'(sec_pix_i[ch*CHAN_W +: CHAN_W]) * PROD_W'(coef_b);
        end
        EFF_BRIGHT: begin
          prod_d[ch] = PROD_W'(CHAN_MAX - top_pix_i[ch*CHAN_W +: CHAN_W]) *
                       PROD_W'(coef_y);
        end
        EFF_DARK: begin
          prod_d[ch] = PROD_W'(top_pix_i[ch*CHAN_W +: CHAN_W]) *
                       PROD_W'(COEFF_MAX - coef_y);
        end
        default: begin
          prod_d[ch] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.first) begin
      apply_q <= apply_d;
      pix3_q  <= top_pix_i;
      lay3_q  <= top_lay_i;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        prod_q[ch] <= prod_d[ch];
      end
    end
  end

  // Dividing by sixteen is the drop of the low four product bits.
  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      unique case (cfg_i.effect_mode)
        EFF_ALPHA: begin
          chan_res[ch] = prod_q[ch][PROD_W-1] ? CHAN_MAX
                                              : prod_q[ch][CHAN_W+3:4];
        end
        EFF_BRIGHT: begin
          chan_res[ch] = pix3_q[ch*CHAN_W +: CHAN_W] + prod_q[ch][CHAN_W+3:4];
        end
        default: begin
          chan_res[ch] = prod_q[ch][CHAN_W+3:4];
        end
      endcase
    end
    color_d = apply_q ? {1'b0, chan_res[2], chan_res[1], chan_res[0]} : pix3_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.second) begin
      color_q <= color_d;
      layer_q <= lay3_q;
    end
  end

  assign color_o = color_q;
  assign layer_o = layer_q;

endmodule

`default_nettype wire

>>> src/layer_priority_compositor.sv
// ----------------------------------------------------------------------------
// Layer priority compositor
// Four-stage pipeline: layer qualification, priority selection, effect
// products, effect scaling. Each pixel passes through the stage registers
// in that order; one pixel is taken every cycle while the output is not
// stalled. Reset clears the configuration registers to zero and empties the
// pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_priority_compositor (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [lps_pkg::REG_IDX_W-1:0]        cfg_index_i,
  input  wire [lps_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire [15:0]                          bg0_pixel_i,
  input  wire [15:0]                          bg1_pixel_i,
  input  wire [15:0]                          bg2_pixel_i,
  input  wire [15:0]                          bg3_pixel_i,
  input  wire [15:0]                          sprite_prio0_pixel_i,
  input  wire [15:0]                          sprite_prio1_pixel_i,
  input  wire [15:0]                          sprite_prio2_pixel_i,
  input  wire [15:0]                          sprite_prio3_pixel_i,
  input  wire [5:0]                           visible_mask_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [15:0]                         color_out_o,
  output logic [2:0]                          top_layer_o
);
  import lps_pkg::*;

  cfg_t cfg_q;

  logic [NUM_STAGE-1:0] valid_q, valid_d, ready;

  adv_t   sel_adv, blend_adv;
  pixel_t top_pix, sec_pix;
  layer_t top_lay, sec_lay;
  logic   eff_vis;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_EFFECT_MODE:    cfg_q.effect_mode    <= cfg_data_i[1:0];
        REG_COEFF_A:        cfg_q.coeff_a        <= cfg_data_i[COEFF_W-1:0];
        REG_COEFF_B:        cfg_q.coeff_b        <= cfg_data_i[COEFF_W-1:0];
        REG_COEFF_Y:        cfg_q.coeff_y        <= cfg_data_i[COEFF_W-1:0];
        REG_BG_PRIORITIES:  cfg_q.bg_priorities  <= cfg_data_i[7:0];
        REG_LAYER_ENABLES:  cfg_q.layer_enables  <= cfg_data_i[4:0];
        REG_TARGET_SELECTS: cfg_q.target_selects <= cfg_data_i[11:0];
        REG_BD_COLOR:       cfg_q.bd_color       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage can load when it is empty or the stage after it moves on.
  always_comb begin
    ready[NUM_STAGE-1] = ~valid_q[NUM_STAGE-1] | ~out_stall_i;
    for (int i = NUM_STAGE - 2; i >= 0; i--) begin
      ready[i] = ~valid_q[i] | ready[i+1];
    end
    valid_d[0] = ready[0] ? in_valid_i : valid_q[0];
    for (int i = 1; i < NUM_STAGE; i++) begin
      valid_d[i] = ready[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o       = ~ready[0];
  assign out_valid_o      = valid_q[NUM_STAGE-1];
  assign sel_adv.first    = ready[0];
  assign sel_adv.second   = ready[1];
  assign blend_adv.first  = ready[2];
  assign blend_adv.second = ready[3];

  lps_layer_sel u_layer_sel (
    .clk_i          (clk_i),
    .cfg_i          (cfg_q),
    .adv_i          (sel_adv),
    .bg_pixel_i     ({bg3_pixel_i, bg2_pixel_i, bg1_pixel_i, bg0_pixel_i}),
    .spr_pixel_i    ({sprite_prio3_pixel_i, sprite_prio2_pixel_i,
                      sprite_prio1_pixel_i, sprite_prio0_pixel_i}),
    .visible_mask_i (visible_mask_i),
    .top_pix_o      (top_pix),
    .sec_pix_o      (sec_pix),
    .top_lay_o      (top_lay),
    .sec_lay_o      (sec_lay),
    .eff_vis_o      (eff_vis)
  );

  lps_blend u_blend (
    .clk_i     (clk_i),
    .cfg_i     (cfg_q),
    .adv_i     (blend_adv),
    .top_pix_i (top_pix),
    .sec_pix_i (sec_pix),
    .top_lay_i (top_lay),
    .sec_lay_i (sec_lay),
    .eff_vis_i (eff_vis),
    .color_o   (color_out_o),
    .layer_o   (top_layer_o)
  );

  // An empty output stage means the whole pipeline can move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the output stage is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (top_layer_o <= LAYER_BACKDROP))
    else $error("top layer code out of range");

  // With every layer disabled only the backdrop can win.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cfg_q.layer_enables == '0) |-> (top_layer_o == LAYER_BACKDROP))
    else $error("a disabled layer won the pixel");

endmodule

`default_nettype wire
